@@ src/sfbs_pkg.sv @@
// shared types and constants of the serial frame byte stuffer
`default_nettype none

package sfbs_pkg;

    // framing and escape codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] TYPE_BYTE = 8'h42;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // record layout
    localparam int POS_W     = 9;
    localparam int HDR_FIRST = 6;
    localparam int LEN_POS   = 9;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified request: which parts of the frame it emits
    typedef struct packed {
        logic       open;
        logic       data;
        logic       len;
        logic       close;
        logic [7:0] data_byte;
        logic [7:0] len_byte;
    } sfbs_cmd_t;

    // output sequencer phases
    typedef enum logic [3:0] {
        PH_START,
        PH_FLAG_OPEN,
        PH_TYPE,
        PH_DATA,
        PH_DATA_ESC,
        PH_LEN,
        PH_CK0,
        PH_CK1,
        PH_FLAG_CLOSE
    } sfbs_phase_t;

endpackage

`default_nettype wire

@@ src/sfbs_front.sv @@
// front part: tracks the record position and classifies each request
`default_nettype none

module sfbs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        record_byte,
    input  wire logic              first_byte,
    output sfbs_pkg::sfbs_cmd_t    cmd,
    output logic                   push
);
    import sfbs_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       length_reg, length_next;
    logic             active_reg, active_next;
    logic             is_close;

    // close when position reaches the last payload byte
    assign is_close = ({1'b0, pos_reg} == (10'(LEN_POS) + {2'b00, length_reg}));

    // classification and next state
    always_comb
    begin
        pos_next      = pos_reg;
        length_next   = length_reg;
        active_next   = active_reg;
        cmd.open      = 1'b0;
        cmd.data      = 1'b0;
        cmd.len       = 1'b0;
        cmd.close     = 1'b0;
        cmd.data_byte = record_byte;
        cmd.len_byte  = length_reg;
        push          = 1'b0;
        if (first_byte)
        begin
            cmd.open    = 1'b1;
            push        = accept;
            length_next = record_byte;
            pos_next    = POS_W'(1);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            cmd.data    = (pos_reg >= POS_W'(HDR_FIRST));
            cmd.len     = (pos_reg == POS_W'(LEN_POS));
            cmd.close   = is_close;
            push        = accept && (cmd.data || cmd.len || cmd.close);
            pos_next    = pos_reg + 1'b1;
            active_next = !is_close;
        end
    end

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            length_reg <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            length_reg <= length_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

@@ src/sfbs_queue.sv @@
// short command queue between front and back
`default_nettype none

module sfbs_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sfbs_pkg::sfbs_cmd_t push_cmd,
    input  wire logic                pop,
    output sfbs_pkg::sfbs_cmd_t      head,
    output logic                     head_valid,
    output logic                     full
);
    import sfbs_pkg::*;

    sfbs_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // queue checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

@@ src/sfbs_back.sv @@
// back part: expands commands into stuffed bytes through the output register
`default_nettype none

module sfbs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sfbs_pkg::sfbs_cmd_t head,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               out_byte,
    output logic                     run_last,
    output logic                     frame_end
);
    import sfbs_pkg::*;

    sfbs_phase_t phase_reg, phase_next;
    sfbs_phase_t cur_phase, step_phase, after_data;
    logic        after_data_last;
    logic        needs_esc;
    logic        load, emit;
    logic [7:0]  byte_next;
    logic        last_next, end_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        run_last_reg, frame_end_reg;

    assign load      = !out_valid_reg || !out_stall;
    assign emit      = load && head_valid;
    assign needs_esc = (head.data_byte == FLAG_BYTE) || (head.data_byte == ESC_BYTE);

    // phase that follows the data byte
    always_comb
    begin
        if (head.len)
            after_data = PH_LEN;
        else if (head.close)
            after_data = PH_CK0;
        else
            after_data = PH_START;
        after_data_last = !head.len && !head.close;
    end

    // phase sequencer and byte selection
    always_comb
    begin
        if (phase_reg != PH_START)
            cur_phase = phase_reg;
        else if (head.open)
            cur_phase = PH_FLAG_OPEN;
        else if (head.data)
            cur_phase = PH_DATA;
        else if (head.len)
            cur_phase = PH_LEN;
        else
            cur_phase = PH_CK0;

        step_phase = PH_START;
        byte_next  = 8'h00;
        last_next  = 1'b0;
        end_next   = 1'b0;
        unique case (cur_phase)
            PH_FLAG_OPEN:
            begin
                byte_next  = FLAG_BYTE;
                step_phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                byte_next = TYPE_BYTE;
                last_next = 1'b1;
            end
            PH_DATA:
            begin
                if (needs_esc)
                begin
                    byte_next  = ESC_BYTE;
                    step_phase = PH_DATA_ESC;
                end
                else
                begin
                    byte_next  = head.data_byte;
                    step_phase = after_data;
                    last_next  = after_data_last;
                end
            end
            PH_DATA_ESC:
            begin
                byte_next  = (head.data_byte == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
                step_phase = after_data;
                last_next  = after_data_last;
            end
            PH_LEN:
            begin
                byte_next  = head.len_byte;
                step_phase = head.close ? PH_CK0 : PH_START;
                last_next  = !head.close;
            end
            PH_CK0:
            begin
                step_phase = PH_CK1;
            end
            PH_CK1:
            begin
                step_phase = PH_FLAG_CLOSE;
            end
            PH_FLAG_CLOSE:
            begin
                byte_next = FLAG_BYTE;
                last_next = 1'b1;
                end_next  = 1'b1;
            end
            default:
            begin
                last_next = 1'b1;
            end
        endcase
        phase_next = last_next ? PH_START : step_phase;
    end

    assign pop = emit && last_next;

    // phase and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
            if (head_valid)
                phase_reg <= phase_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= byte_next;
            run_last_reg  <= last_next;
            frame_end_reg <= end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

    // sequencer checks
    a_end_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> (run_last_reg && out_byte_reg == FLAG_BYTE))
        else $error("frame end not on a closing flag");
    a_mid_cmd_head: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_START) |-> head_valid)
        else $error("command in progress without queue head");
    a_esc_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA_ESC) |-> (out_valid_reg && out_byte_reg == ESC_BYTE))
        else $error("escape code pending without escape byte shown");

endmodule

`default_nettype wire

@@ src/serial_frame_byte_stuffer.sv @@
// Serial frame byte stuffer: a request is taken in any cycle the command queue has room.
// Its frame bytes pass through the command queue and then the output register.
// The back sequencer sends one frame byte per cycle while out_stall is low and a command is queued;
// a request yields 0 to 6 bytes, so sustained input is bounded by the bytes each request produces.
// The four-entry command queue lets input run ahead of a stalled output.
// Asynchronous active-low reset clears position, length, frame state, queue and output valid.
`default_nettype none

module serial_frame_byte_stuffer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] record_byte,
    input  wire logic       first_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            frame_end
);
    import sfbs_pkg::*;

    sfbs_cmd_t front_cmd;
    sfbs_cmd_t head;
    logic      push, pop, head_valid, full, accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // request classification
    sfbs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .record_byte (record_byte),
        .first_byte  (first_byte),
        .cmd         (front_cmd),
        .push        (push)
    );

    // command queue
    sfbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (front_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // byte expansion and output
    sfbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
